FILE: src/psd_pkg.sv
// shared types and constants for the point to segment distance block
// no dependencies
package psd_pkg;

  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 8;

  localparam int DIFF_W = COORD_BITS + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int SUM_W  = 2 * COORD_BITS + 2;
  localparam int SQ_W   = 2 * COORD_BITS + 1;
  localparam int CR_W   = 2 * COORD_BITS + 1;
  localparam int RAD_W  = SQ_W + 2 * FRAC_BITS;
  localparam int ROOT_W = (RAD_W + 1) / 2;
  localparam int NUM_W  = 2 * CR_W + 2 * FRAC_BITS;
  localparam int REM_W  = SQ_W + 1;

  localparam int DIST_W = 21;
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  localparam int MQ_AW    = 2;
  localparam int MQ_DEPTH = 1 << MQ_AW;

  typedef enum logic [1:0] {
    CASE_B     = 2'd0,
    CASE_A     = 2'd1,
    CASE_PERP  = 2'd2,
    CASE_DEGEN = 2'd3
  } kind_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] ax;
    logic signed [COORD_BITS-1:0] ay;
    logic signed [COORD_BITS-1:0] bx;
    logic signed [COORD_BITS-1:0] by;
    logic signed [COORD_BITS-1:0] cx;
    logic signed [COORD_BITS-1:0] cy;
  } in_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic [1:0]        nearest_case;
  } out_t;

  // classified query handed from front to back
  typedef struct packed {
    kind_t             kind;
    logic [RAD_W-1:0]  rad;
    logic [SQ_W-1:0]   ab2;
    logic [CR_W-1:0]   ucr;
  } mid_t;

endpackage

FILE: src/psd_front.sv
// front part: differences, products and case classification
// depends on psd_pkg
module psd_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  psd_pkg::in_t  item,
  output logic          q_wr,
  output psd_pkg::mid_t q_data,
  input  logic          q_full
);
  import psd_pkg::*;

  logic adv;
  logic v1, v2, v3;

  logic signed [DIFF_W-1:0] abx, aby, bcx, bcy, acx, acy;
  logic signed [PROD_W-1:0] p_abbc_x, p_abbc_y, p_abac_x, p_abac_y;
  logic signed [PROD_W-1:0] p_cr_a, p_cr_b, p_abx2, p_aby2, p_acx2, p_acy2;
  logic signed [PROD_W-1:0] p_bcx2, p_bcy2;
  mid_t f3;

  logic signed [SUM_W-1:0] dot_bc, dot_ac, cr;
  logic [SQ_W-1:0] len_ac, len_bc, ab2;
  logic ab_zero;
  mid_t f3_next;

  assign adv  = !(v3 && q_full);
  assign full = !adv;
  assign q_wr = v3 && !q_full;
  assign q_data = f3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v1 <= push;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_comb begin
    dot_bc = SUM_W'(p_abbc_x) + SUM_W'(p_abbc_y);
    dot_ac = SUM_W'(p_abac_x) + SUM_W'(p_abac_y);
    cr     = SUM_W'(p_cr_a) - SUM_W'(p_cr_b);
    len_ac = SQ_W'($unsigned(p_acx2)) + SQ_W'($unsigned(p_acy2));
    len_bc = SQ_W'($unsigned(p_bcx2)) + SQ_W'($unsigned(p_bcy2));
    ab2    = SQ_W'($unsigned(p_abx2)) + SQ_W'($unsigned(p_aby2));
    ab_zero = (ab2 == '0);
    f3_next.ab2 = ab2;
    f3_next.ucr = CR_W'(cr[SUM_W-1] ? -cr : cr);
    f3_next.rad = RAD_W'(len_ac) << (2 * FRAC_BITS);
    if (!dot_bc[SUM_W-1] && dot_bc != '0) begin
      f3_next.kind = CASE_B;
      f3_next.rad  = RAD_W'(len_bc) << (2 * FRAC_BITS);
    end else if (dot_ac[SUM_W-1]) begin
      f3_next.kind = CASE_A;
    end else if (ab_zero) begin
      f3_next.kind = CASE_DEGEN;
    end else begin
      f3_next.kind = CASE_PERP;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      abx <= DIFF_W'(item.bx) - DIFF_W'(item.ax);
      aby <= DIFF_W'(item.by) - DIFF_W'(item.ay);
      bcx <= DIFF_W'(item.cx) - DIFF_W'(item.bx);
      bcy <= DIFF_W'(item.cy) - DIFF_W'(item.by);
      acx <= DIFF_W'(item.cx) - DIFF_W'(item.ax);
      acy <= DIFF_W'(item.cy) - DIFF_W'(item.ay);
      p_abbc_x <= PROD_W'(abx) * PROD_W'(bcx);
      p_abbc_y <= PROD_W'(aby) * PROD_W'(bcy);
      p_abac_x <= PROD_W'(abx) * PROD_W'(acx);
      p_abac_y <= PROD_W'(aby) * PROD_W'(acy);
      p_cr_a   <= PROD_W'(abx) * PROD_W'(acy);
      p_cr_b   <= PROD_W'(acx) * PROD_W'(aby);
      p_abx2   <= PROD_W'(abx) * PROD_W'(abx);
      p_aby2   <= PROD_W'(aby) * PROD_W'(aby);
      p_acx2   <= PROD_W'(acx) * PROD_W'(acx);
      p_acy2   <= PROD_W'(acy) * PROD_W'(acy);
      p_bcx2   <= PROD_W'(bcx) * PROD_W'(bcx);
      p_bcy2   <= PROD_W'(bcy) * PROD_W'(bcy);
      f3 <= f3_next;
    end
  end

endmodule

FILE: src/psd_queue.sv
// short queue of classified queries between front and back
// depends on psd_pkg
module psd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr,
  input  psd_pkg::mid_t wr_data,
  output logic          full,
  input  logic          rd,
  output psd_pkg::mid_t rd_data,
  output logic          empty
);
  import psd_pkg::*;

  mid_t entries [MQ_DEPTH];
  logic [MQ_AW-1:0] wptr, rptr;
  logic [MQ_AW:0]   count;
  logic do_wr, do_rd;

  assign full  = (count == (MQ_AW+1)'(MQ_DEPTH));
  assign empty = (count == '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rd_data = entries[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) wptr <= wptr + 1'b1;
      if (do_rd) rptr <= rptr + 1'b1;
      count <= count + (MQ_AW+1)'(do_wr) - (MQ_AW+1)'(do_rd);
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) entries[wptr] <= wr_data;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (MQ_AW+1)'(MQ_DEPTH))
    else $error("queue count above depth");

endmodule

FILE: src/psd_back.sv
// back part: squaring, pipelined divider, pipelined square root, result queue
// depends on psd_pkg
module psd_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_empty,
  input  psd_pkg::mid_t q_data,
  output logic          q_rd,
  input  logic          pop,
  output logic          empty,
  output psd_pkg::out_t result
);
  import psd_pkg::*;

  typedef struct packed {
    kind_t              kind;
    logic [REM_W-1:0]   rem;
    logic [RAD_W-1:0]   nlo;
    logic [RAD_W-1:0]   q;
    logic [SQ_W-1:0]    d;
  } div_st_t;

  typedef struct packed {
    kind_t                 kind;
    logic [2*ROOT_W-1:0]   rad;
    logic [ROOT_W+1:0]     rem;
    logic [ROOT_W-1:0]     root;
  } sqr_st_t;

  typedef struct packed {
    kind_t              kind;
    logic [RAD_W-1:0]   rad;
    logic [SQ_W-1:0]    ab2;
    logic [2*CR_W-1:0]  prod;
  } b1_t;

  function automatic div_st_t div_step(div_st_t s);
    div_st_t r;
    logic [REM_W-1:0] t;
    r = s;
    t = {s.rem[REM_W-2:0], s.nlo[RAD_W-1]};
    if (s.kind == CASE_PERP) begin
      r.nlo = s.nlo << 1;
      if (t >= REM_W'(s.d)) begin
        r.rem = t - REM_W'(s.d);
        r.q   = {s.q[RAD_W-2:0], 1'b1};
      end else begin
        r.rem = t;
        r.q   = {s.q[RAD_W-2:0], 1'b0};
      end
    end
    return r;
  endfunction

  function automatic sqr_st_t sqr_step(sqr_st_t s);
    sqr_st_t r;
    logic [ROOT_W+3:0] t, trial;
    r = s;
    t = {s.rem, s.rad[2*ROOT_W-1 -: 2]};
    trial = (ROOT_W+4)'({s.root, 2'b01});
    r.rad = s.rad << 2;
    if (t >= trial) begin
      r.rem  = (ROOT_W+2)'(t - trial);
      r.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      r.rem  = (ROOT_W+2)'(t);
      r.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    return r;
  endfunction

  logic adv;
  logic b0v, b1v;
  logic [RAD_W:0]  dv;
  logic [ROOT_W:0] sv;
  mid_t    b0;
  b1_t     b1;
  div_st_t dst [RAD_W+1];
  sqr_st_t sst [ROOT_W+1];

  logic [NUM_W-1:0] num;
  div_st_t dinit;
  sqr_st_t sinit;
  logic [63:0] root_wide;
  out_t    oitem;
  out_t    oq [2];
  logic [1:0] ocount;
  logic push_o, pop_o;
  logic idx;

  assign adv  = (ocount != 2'd2);
  assign q_rd = adv && !q_empty;

  always_comb begin
    num = NUM_W'(b1.prod) << (2 * FRAC_BITS);
    dinit.kind = b1.kind;
    dinit.rem  = REM_W'(num[NUM_W-1:RAD_W]);
    dinit.nlo  = num[RAD_W-1:0];
    dinit.q    = (b1.kind == CASE_PERP) ? '0 : b1.rad;
    dinit.d    = b1.ab2;
    sinit.kind = dst[RAD_W].kind;
    sinit.rad  = (2*ROOT_W)'(dst[RAD_W].q);
    sinit.rem  = '0;
    sinit.root = '0;
    root_wide  = 64'(sst[ROOT_W].root);
    oitem.distance = (root_wide > 64'(DIST_MAX)) ? DIST_MAX : DIST_W'(root_wide);
    oitem.nearest_case = sst[ROOT_W].kind;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b0v <= 1'b0;
      b1v <= 1'b0;
      dv  <= '0;
      sv  <= '0;
    end else if (adv) begin
      b0v <= !q_empty;
      b1v <= b0v;
      dv  <= {dv[RAD_W-1:0], b1v};
      sv  <= {sv[ROOT_W-1:0], dv[RAD_W]};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b0 <= q_data;
      b1.kind <= b0.kind;
      b1.rad  <= b0.rad;
      b1.ab2  <= b0.ab2;
      b1.prod <= (2*CR_W)'(b0.ucr) * (2*CR_W)'(b0.ucr);
      dst[0] <= dinit;
      for (int k = 0; k < RAD_W; k++) dst[k+1] <= div_step(dst[k]);
      sst[0] <= sinit;
      for (int k = 0; k < ROOT_W; k++) sst[k+1] <= sqr_step(sst[k]);
    end
  end

  // two entry result queue, head always at slot zero
  assign push_o = adv && sv[ROOT_W];
  assign pop_o  = pop && (ocount != 2'd0);
  assign idx    = 1'((ocount - 2'(pop_o)));
  assign empty  = (ocount == 2'd0);
  assign result = oq[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      ocount <= 2'd0;
    end else begin
      ocount <= ocount + 2'(push_o) - 2'(pop_o);
    end
  end

  always_ff @(posedge clk) begin
    if (push_o && !idx) begin
      oq[0] <= oitem;
    end else if (pop_o) begin
      oq[0] <= oq[1];
    end
    if (push_o && idx) oq[1] <= oitem;
  end

  a_ocount_bound: assert property (@(posedge clk) disable iff (rst)
    ocount <= 2'd2)
    else $error("result queue overflow");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (!adv && sv[ROOT_W]) |=> sv[ROOT_W])
    else $error("finished transaction lost during stall");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push_o |-> ocount < 2'd2)
    else $error("result pushed into full queue");

endmodule

FILE: src/point_segment_distance.sv
// top level of the point to segment distance block
// depends on psd_pkg, psd_front, psd_queue, psd_back
//
// Shortest distance from point C to segment AB, floor(distance * 256), with the
// case code (B nearest, A nearest, perpendicular foot, A equals B). One
// transaction is accepted per cycle and one result leaves per cycle while
// neither side stalls. The arithmetic back runs through the one-bit-per-stage
// divider (41 stages) and root extractor (21 stages). A four-entry queue
// between the classifying front and the arithmetic back, and a two-entry
// result queue, let either side stall without losing transactions.
module point_segment_distance (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  psd_pkg::in_t  item,
  output logic          empty,
  input  logic          pop,
  output psd_pkg::out_t result
);
  import psd_pkg::*;

  logic mq_wr, mq_full, mq_rd, mq_empty;
  mid_t mq_wdata, mq_rdata;

  psd_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .q_wr   (mq_wr),
    .q_data (mq_wdata),
    .q_full (mq_full)
  );

  psd_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (mq_wr),
    .wr_data (mq_wdata),
    .full    (mq_full),
    .rd      (mq_rd),
    .rd_data (mq_rdata),
    .empty   (mq_empty)
  );

  psd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (mq_empty),
    .q_data  (mq_rdata),
    .q_rd    (mq_rd),
    .pop     (pop),
    .empty   (empty),
    .result  (result)
  );

endmodule

FILE: verif/point_segment_distance_tb.sv
// testbench for point_segment_distance: directed table, then random queries
// depends on psd_pkg and the point_segment_distance block
module point_segment_distance_tb;
  import psd_pkg::*;

  typedef struct {
    in_t         pt;
    bit          typed;
    logic [20:0] want_dist;
    kind_t       kc;
  } query_row_t;

  localparam int NUM_ROWS = 14;

  logic  clk;
  logic  rst;
  logic  push;
  logic  full;
  in_t   item;
  logic  empty;
  logic  pop;
  out_t  result;

  out_t  dist_q[$];
  int    mismatch_count;
  int    send_idle_pct;
  int    recv_idle_pct;
  bit    hold_req;

  query_row_t rows[NUM_ROWS] = '{
    '{'{12'sd0, 12'sd0, 12'sd0, 12'sd0, 12'sd0, 12'sd0}, 1, 21'd0, CASE_DEGEN},
    '{'{12'sd0, 12'sd0, 12'sd0, 12'sd0, 12'sd3, 12'sd4}, 1, 21'd1280, CASE_DEGEN},
    '{'{12'sd0, 12'sd0, 12'sd10, 12'sd0, 12'sd20, 12'sd0}, 1, 21'd2560, CASE_B},
    '{'{12'sd0, 12'sd0, 12'sd10, 12'sd0, -12'sd5, 12'sd0}, 1, 21'd1280, CASE_A},
    '{'{12'sd0, 12'sd0, 12'sd10, 12'sd0, 12'sd5, 12'sd3}, 1, 21'd768, CASE_PERP},
    '{'{12'sd0, 12'sd0, 12'sd10, 12'sd0, 12'sd10, 12'sd0}, 1, 21'd0, CASE_PERP},
    '{'{12'sd0, 12'sd0, 12'sd10, 12'sd0, 12'sd0, 12'sd0}, 1, 21'd0, CASE_PERP},
    '{'{-12'sd2048, -12'sd2048, 12'sd2047, 12'sd2047, 12'sd2047, -12'sd2048}, 0, 0,
      CASE_B},
    '{'{12'sd2047, 12'sd2047, 12'sd2047, 12'sd2047, -12'sd2048, -12'sd2048}, 0, 0,
      CASE_B},
    '{'{-12'sd2048, -12'sd2048, -12'sd2048, -12'sd2048, 12'sd2047, 12'sd2047}, 0, 0,
      CASE_B},
    '{'{-12'sd2048, 12'sd2047, 12'sd2047, -12'sd2048, -12'sd2048, -12'sd2048}, 0, 0,
      CASE_B},
    '{'{-12'sd2048, 12'sd0, 12'sd2047, 12'sd0, 12'sd2047, 12'sd2047}, 0, 0, CASE_B},
    '{'{12'sd2047, 12'sd0, -12'sd2048, 12'sd0, 12'sd2047, -12'sd2048}, 0, 0, CASE_B},
    '{'{12'sd1, -12'sd1, -12'sd1, 12'sd1, 12'sd2047, 12'sd2047}, 0, 0, CASE_B}
  };

  point_segment_distance i_dut (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [63:0] floor_root(logic [127:0] v);
    logic [63:0]  root;
    logic [127:0] t;
    root = '0;
    for (int i = 63; i >= 0; i--) begin
      t = {64'd0, root | (64'd1 << i)};
      if (t * t <= v) root = t[63:0];
    end
    return root;
  endfunction

  function automatic logic [63:0] scaled_length(longint dx, longint dy);
    logic [127:0] rad;
    rad = 128'(dx * dx + dy * dy) << (2 * FRAC_BITS);
    return floor_root(rad);
  endfunction

  function automatic out_t nearest_dist(in_t q);
    longint       abx, aby, bcx, bcy, acx, acy, dot_bc, dot_ac, cr, ab2;
    logic [63:0]  d;
    logic [127:0] num;
    out_t         r;
    abx = longint'(q.bx) - longint'(q.ax);
    aby = longint'(q.by) - longint'(q.ay);
    bcx = longint'(q.cx) - longint'(q.bx);
    bcy = longint'(q.cy) - longint'(q.by);
    acx = longint'(q.cx) - longint'(q.ax);
    acy = longint'(q.cy) - longint'(q.ay);
    dot_bc = abx * bcx + aby * bcy;
    dot_ac = abx * acx + aby * acy;
    if (dot_bc > 0) begin
      r.nearest_case = CASE_B;
      d = scaled_length(bcx, bcy);
    end else if (dot_ac < 0) begin
      r.nearest_case = CASE_A;
      d = scaled_length(acx, acy);
    end else if (abx == 0 && aby == 0) begin
      r.nearest_case = CASE_DEGEN;
      d = scaled_length(acx, acy);
    end else begin
      cr = abx * acy - acx * aby;
      if (cr < 0) cr = -cr;
      ab2 = abx * abx + aby * aby;
      num = (128'(cr) * 128'(cr)) << (2 * FRAC_BITS);
      d = floor_root(num / 128'(ab2));
      r.nearest_case = CASE_PERP;
    end
    r.distance = (d > 64'(DIST_MAX)) ? DIST_MAX : d[DIST_W-1:0];
    return r;
  endfunction

  function automatic logic signed [11:0] coord_near(int span);
    return 12'($signed($urandom_range(2 * span)) - span);
  endfunction

  // random query, shaped so that every case and the edge geometry come up often
  function automatic in_t random_query();
    in_t q;
    int  span;
    int  pick;
    pick = $urandom_range(9);
    span = (pick < 4) ? 2047 : (pick < 7) ? 40 : 3;
    q.ax = (span == 2047) ? 12'($urandom) : coord_near(span);
    q.ay = (span == 2047) ? 12'($urandom) : coord_near(span);
    q.bx = (span == 2047) ? 12'($urandom) : coord_near(span);
    q.by = (span == 2047) ? 12'($urandom) : coord_near(span);
    q.cx = (span == 2047) ? 12'($urandom) : coord_near(span);
    q.cy = (span == 2047) ? 12'($urandom) : coord_near(span);
    if (pick == 9) begin
      q.bx = q.ax;
      q.by = q.ay;
    end else if (pick == 8) begin
      // C at endpoint B
      q.cx = q.bx;
      q.cy = q.by;
    end
    return q;
  endfunction

  task automatic send_query(in_t q, bit typed, out_t exp_val);
    item = q;
    push = 1'b1;
    do @(posedge clk); while (full);
    dist_q.push_back(typed ? exp_val : nearest_dist(q));
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      push = 1'b0;
      item = in_t'(72'({$urandom, $urandom, $urandom}));
      @(negedge clk);
    end
    push = 1'b0;
  endtask

  // receiver: pop and compare against the oldest expectation
  initial begin
    pop = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        pop = 1'b0;
        repeat (300) @(negedge clk);
        hold_req = 1'b0;
      end
      pop = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (dist_q.size() == 0) begin
        $display("%0t: unexpected transaction distance=%0d case=%0d", $time,
                 result.distance, result.nearest_case);
        mismatch_count++;
      end else begin
        if (result.distance !== dist_q[0].distance) begin
          $display("%0t: distance expected %0d actual %0d", $time,
                   dist_q[0].distance, result.distance);
          mismatch_count++;
        end
        if (result.nearest_case !== dist_q[0].nearest_case) begin
          $display("%0t: nearest_case expected %0d actual %0d", $time,
                   dist_q[0].nearest_case, result.nearest_case);
          mismatch_count++;
        end
        void'(dist_q.pop_front());
      end
    end
  end

  initial begin
    #3000000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    out_t ev;
    rst = 1'b1;
    push = 1'b0;
    item = '0;
    mismatch_count = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (rows[i]) begin
      ev.distance = rows[i].want_dist;
      ev.nearest_case = rows[i].kc;
      send_query(rows[i].pt, rows[i].typed, ev);
    end

    // fill the block while the receiver holds off
    hold_req = 1'b1;
    for (int i = 0; i < 100; i++) send_query(random_query(), 0, ev);
    wait (dist_q.size() == 0);
    @(negedge clk);

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1) ? 51 : (ph == 3) ? 26 : 0;
      recv_idle_pct = (ph == 2) ? 51 : (ph == 3) ? 26 : 0;
      for (int i = 0; i < 120; i++) send_query(random_query(), 0, ev);
      if (ph == 1) begin
        wait (dist_q.size() == 0);
        @(negedge clk);
      end
    end
    send_idle_pct = 0;
    recv_idle_pct = 0;

    wait (dist_q.size() == 0);
    repeat (200) @(posedge clk);
    if (mismatch_count == 0 && dist_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
